@@ rtl/sppc_pkg.sv @@
// Shared constants, payload types and command codes for the segment
// piston/tip/tilt channel combiner. No dependencies.
package sppc_pkg;

    // Geometry
    localparam int CHANNELS  = 4;
    localparam int SEGMENTS  = 169;
    localparam int CH_W      = 2;
    localparam int SEG_W     = 8;
    localparam int IDX_W     = 9;

    // Field and register widths
    localparam int VAL_W     = 24;
    localparam int SUM_W     = 27;
    localparam int DRV_W     = 16;
    localparam int ACT_W     = 3;
    localparam int SCALE_W   = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    // Datapath widths
    localparam int COEF_W    = 25;
    localparam int PRD_W     = 51;
    localparam int ACC_W     = 53;
    localparam int FRAC_SH   = 16;
    localparam int V8_W      = ACC_W - FRAC_SH;
    localparam int MAG_W     = V8_W - 1;
    localparam int MAG_HALF  = MAG_W / 2;
    localparam int PP_W      = MAG_HALF + SCALE_W;
    localparam int SPROD_W   = MAG_W + SCALE_W;
    localparam int SCALE_SH  = 24;

    // Job queue
    localparam int QDEPTH    = 2;
    localparam int QP_W      = 1;
    localparam int QC_W      = 2;

    // Lever coefficients, 16 fractional bits
    localparam logic signed [COEF_W-1:0] COEF_TIP  = 25'sd12415340;
    localparam logic signed [COEF_W-1:0] COEF_HALF = 25'sd7168000;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 1'd1;
    localparam logic [ACT_W-1:0]     ACTIVE_RST = 3'd4;
    localparam logic [SCALE_W-1:0]   SCALE_RST  = 24'd1073742;

    // Actuator select codes
    localparam logic [1:0] SEL_A0 = 2'd0;
    localparam logic [1:0] SEL_A1 = 2'd1;
    localparam logic [1:0] SEL_A2 = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic [SEG_W-1:0]        segment;
        logic signed [VAL_W-1:0] piston;
        logic signed [VAL_W-1:0] tip;
        logic signed [VAL_W-1:0] tilt;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] actuator_index;
        logic [DRV_W-1:0] drive_value;
        logic             last;
    } t_out;

    typedef struct packed {
        logic signed [VAL_W-1:0] piston;
        logic signed [VAL_W-1:0] tip;
        logic signed [VAL_W-1:0] tilt;
    } t_triple;

    // One memory row per segment: every channel's triple plus the sums
    typedef struct packed {
        t_triple [CHANNELS-1:0]  chan;
        logic signed [SUM_W-1:0] sum_p;
        logic signed [SUM_W-1:0] sum_t;
        logic signed [SUM_W-1:0] sum_y;
    } t_row;

    // Command issue from the sequencer to the drive pipeline
    typedef struct packed {
        logic             vld;
        logic [1:0]       sel;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_cmd;

    // Operands held by the sequencer while its commands issue
    typedef struct packed {
        logic signed [SUM_W-1:0] sp;
        logic signed [PRD_W-1:0] pa;
        logic signed [PRD_W-1:0] pb;
    } t_opnd;

endpackage

@@ rtl/sppc_front.sv @@
// Input side: filters items by active channel count and segment range
// and queues the kept ones. Depends on sppc_pkg.
module sppc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sppc_pkg::ACT_W-1:0] i_active,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  sppc_pkg::t_in              i_in_data,
    output logic                       o_job_valid,
    output sppc_pkg::t_in              o_job,
    input  logic                       i_job_pop
);
    import sppc_pkg::*;

    logic [ACT_W-1:0] act_eff;
    logic             keep;
    logic             push;
    t_in              r_q [QDEPTH];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic [QC_W-1:0]  n_cnt;

    // Clamp the active count to 1..CHANNELS
    always_comb begin
        if (i_active == '0) begin
            act_eff = ACT_W'(1);
        end else if (i_active > ACT_W'(CHANNELS)) begin
            act_eff = ACT_W'(CHANNELS);
        end else begin
            act_eff = i_active;
        end
    end

    // Drop beats for inactive channels or segments out of range
    assign keep = ({1'b0, i_in_data.channel} < act_eff) &&
                  (i_in_data.segment < SEG_W'(SEGMENTS));

    assign o_in_ready  = (r_cnt != QC_W'(QDEPTH));
    assign push        = i_in_valid && o_in_ready && keep;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_job_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!push && i_job_pop) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + QP_W'(1);
            end
            if (i_job_pop) begin
                r_rp <= r_rp + QP_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in_data;
        end
    end

endmodule

@@ rtl/sppc_update.sv @@
// Sequencer: read-modify-write of the segment row memory, sum update,
// lever products and issue of three commands per job. Depends on sppc_pkg.
module sppc_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  sppc_pkg::t_in   i_job,
    output logic            o_job_pop,
    output sppc_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_ready,
    output sppc_pkg::t_opnd o_opnd
);
    import sppc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_MUL  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    t_row                    r_mem [SEGMENTS];
    logic [SEGMENTS-1:0]     r_vld;
    t_row                    r_rd_row;
    logic                    r_rd_hit;
    t_in                     r_job;
    logic [IDX_W-1:0]        r_base;
    logic signed [SUM_W-1:0] r_sp;
    logic signed [SUM_W-1:0] r_st;
    logic signed [SUM_W-1:0] r_sy;
    logic signed [PRD_W-1:0] r_pa;
    logic signed [PRD_W-1:0] r_pb;
    logic [1:0]              r_k;
    logic                    emit_last;
    t_row                    row;
    t_triple                 old_v;
    t_row                    new_row;

    assign emit_last = (r_state == S_EMIT) && i_cmd_ready && (r_k == SEL_A2);
    assign o_job_pop = i_job_valid && ((r_state == S_IDLE) || emit_last);

    // Fold the new triple into the row; rows never written read as zero
    always_comb begin
        row   = r_rd_hit ? r_rd_row : '0;
        old_v = row.chan[r_job.channel];
        new_row = row;
        new_row.chan[r_job.channel] = {r_job.piston, r_job.tip, r_job.tilt};
        new_row.sum_p = row.sum_p - SUM_W'(old_v.piston) + SUM_W'(r_job.piston);
        new_row.sum_t = row.sum_t - SUM_W'(old_v.tip) + SUM_W'(r_job.tip);
        new_row.sum_y = row.sum_y - SUM_W'(old_v.tilt) + SUM_W'(r_job.tilt);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = i_job_valid ? S_UPD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_k     <= SEL_A0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_vld[r_job.segment] <= 1'b1;
            end
            if (r_state == S_MUL) begin
                r_k <= SEL_A0;
            end else if ((r_state == S_EMIT) && i_cmd_ready) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    // Row memory: write back in the update step, read on pop
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_mem[r_job.segment] <= new_row;
        end
        if (o_job_pop) begin
            r_rd_row <= r_mem[i_job.segment];
        end
    end

    // Job payload, sums and lever products
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job    <= i_job;
            r_rd_hit <= r_vld[i_job.segment];
            r_base   <= IDX_W'({i_job.segment, 1'b0}) + IDX_W'(i_job.segment);
        end
        if (r_state == S_UPD) begin
            r_sp <= new_row.sum_p;
            r_st <= new_row.sum_t;
            r_sy <= new_row.sum_y;
        end
        if (r_state == S_MUL) begin
            r_pa <= PRD_W'(r_st) * PRD_W'(COEF_TIP);
            r_pb <= PRD_W'(r_sy) * PRD_W'(COEF_HALF);
        end
    end

    assign o_cmd.vld  = (r_state == S_EMIT);
    assign o_cmd.sel  = r_k;
    assign o_cmd.idx  = r_base + IDX_W'(r_k);
    assign o_cmd.last = (r_k == SEL_A2);
    assign o_opnd.sp  = r_sp;
    assign o_opnd.pa  = r_pa;
    assign o_opnd.pb  = r_pb;

endmodule

@@ rtl/sppc_drive.sv @@
// Drive pipeline: forms each actuator command, scales it in two partial
// products, saturates and holds the result beat. Depends on sppc_pkg.
module sppc_drive (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sppc_pkg::SCALE_W-1:0] i_scale,
    input  sppc_pkg::t_cmd               i_cmd,
    input  sppc_pkg::t_opnd              i_opnd,
    output logic                         o_cmd_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output sppc_pkg::t_out               o_out_data
);
    import sppc_pkg::*;

    logic                      en;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   ext_a;
    logic signed [ACC_W-1:0]   ext_b;
    logic signed [ACC_W-1:0]   acc;
    logic [SPROD_W-1:0]        prod;
    logic [DRV_W-1:0]          drv;

    logic                      r_s1_vld;
    logic [V8_W-1:0]           r_s1_v8;
    logic [IDX_W-1:0]          r_s1_idx;
    logic                      r_s1_last;
    logic                      r_s2_vld;
    logic                      r_s2_neg;
    logic [PP_W-1:0]           r_s2_hi;
    logic [PP_W-1:0]           r_s2_lo;
    logic [IDX_W-1:0]          r_s2_idx;
    logic                      r_s2_last;
    logic                      r_out_vld;
    t_out                      r_out;

    // Advance the whole pipe unless a result beat is stuck
    assign en          = !r_out_vld || i_out_ready;
    assign o_cmd_ready = en;

    // Combine the summed piston with the lever products
    always_comb begin
        base  = ACC_W'(i_opnd.sp) <<< FRAC_SH;
        ext_a = ACC_W'(i_opnd.pa);
        ext_b = ACC_W'(i_opnd.pb);
        case (i_cmd.sel)
            SEL_A0:  acc = base + ext_a + ext_b;
            SEL_A1:  acc = base - (ext_b <<< 1);
            SEL_A2:  acc = base - ext_a + ext_b;
            default: acc = base;
        endcase
    end

    // Join the partial products and saturate to the drive range
    always_comb begin
        prod = (SPROD_W'(r_s2_hi) << MAG_HALF) + SPROD_W'(r_s2_lo);
        if (r_s2_neg) begin
            drv = '0;
        end else if (|prod[SPROD_W-1:SCALE_SH+DRV_W]) begin
            drv = '1;
        end else begin
            drv = prod[SCALE_SH+DRV_W-1:SCALE_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= i_cmd.vld;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // floor to 8 fractional bits
            r_s1_v8   <= acc[ACC_W-1:FRAC_SH];
            r_s1_idx  <= i_cmd.idx;
            r_s1_last <= i_cmd.last;
            // split the magnitude into two scale products
            r_s2_neg  <= r_s1_v8[V8_W-1];
            r_s2_hi   <= PP_W'(r_s1_v8[MAG_W-1:MAG_HALF]) * PP_W'(i_scale);
            r_s2_lo   <= PP_W'(r_s1_v8[MAG_HALF-1:0]) * PP_W'(i_scale);
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
            r_out.actuator_index <= r_s2_idx;
            r_out.drive_value    <= drv;
            r_out.last           <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/segment_ptt_channel_combiner_core.sv @@
// Path: an accepted beat is queued; the row read-modify-write sequencer pops
// it with its row read, then runs update, lever multiply and three command
// issues, each command then passing the drive stages to the result register.
// One kept item at a time; the queue holds up to two more; three beats out.
// Reset: synchronous, active low; clears 169 row valid bits at once so all
// stored values and sums read as zero, with no clearing pass; registers
// return to 4 active channels and scale 1073742.
module segment_ptt_channel_combiner_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sppc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sppc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sppc_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sppc_pkg::t_out                 o_out_data
);
    import sppc_pkg::*;

    logic [ACT_W-1:0]   r_active;
    logic [SCALE_W-1:0] r_scale;
    logic               job_valid;
    t_in                job;
    logic               job_pop;
    t_cmd               cmd;
    logic               cmd_ready;
    t_opnd              opnd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
            r_scale  <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE: r_active <= i_cfg_data[ACT_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                default:    r_active <= r_active;
            endcase
        end
    end

    sppc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (r_active),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    sppc_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready),
        .o_opnd      (opnd)
    );

    sppc_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (r_scale),
        .i_cmd       (cmd),
        .i_opnd      (opnd),
        .o_cmd_ready (cmd_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
